/* rtl/core/wss_pkg.sv */
// ============================================================================
// wss_pkg - shared types and constants for the windowed sample statistics unit
// Holds the controller state encoding, the configuration register indexes,
// the link record that travels down the cell chain, and fixed field widths.
// ============================================================================
package wss_pkg;

    // Default depth of the sliding window
    localparam int WINDOW_MAX_DEF = 16;

    // Fixed field widths
    localparam int VAL_W      = 32;
    localparam int MS_W       = 16;
    localparam int CFG_DATA_W = 5;
    localparam int COUNT_W    = 5;

    // Magnitude width of |sample difference| * 1000 (|diff| < 2^32, 1000 < 2^10)
    localparam int RATE_W = 42;

    // Reset value of the window size register
    localparam logic [CFG_DATA_W-1:0] WIN_SIZE_RST = 5'd16;

    // Milliseconds per second, used by the rate conversion
    localparam logic [9:0] RATE_SCALE = 10'd1000;

    // Signed 32-bit limits
    localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_WINDOW_SIZE = 1'b0,
        CFG_DELTA_MODE  = 1'b1
    } t_cfg_idx;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_RATE,
        S_RATE_WAIT,
        S_PLACE,
        S_MOD_WAIT,
        S_WALK_GO,
        S_WALK,
        S_AVG,
        S_AVG_WAIT,
        S_OUT
    } t_state;

    // Running extremes and token flag passed from cell to cell
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] mn;
        logic signed [VAL_W-1:0] mx;
    } t_walk;

endpackage

/* rtl/core/windowed_sample_statistics_unit.sv */
// ============================================================================
// windowed_sample_statistics_unit - sliding window last/average/min/max
// Each input transfer yields one result transfer. One sample is processed at
// a time. While the window is filling, a sample is stored and the totals are
// updated incrementally. Once the window is full, the slot wrap division
// (SLOT_W+1 steps) and the walk of the sum/min/max token down the chain of
// WINDOW_MAX cells recompute them. The bit-serial average division follows
// when more than one value is held; delta mode adds the rate division first.
// All three divisions share one divider. A finished result sits in the output
// register, so the next sample is taken while it waits to be collected.
// ============================================================================
module windowed_sample_statistics_unit
    import wss_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [0:0]              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // sample channel
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic signed [VAL_W-1:0] i_sample_value,
    input  logic [MS_W-1:0]         i_elapsed_ms,
    // result channel
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic signed [VAL_W-1:0] o_last_value,
    output logic signed [VAL_W-1:0] o_window_average,
    output logic signed [VAL_W-1:0] o_window_minimum,
    output logic signed [VAL_W-1:0] o_window_maximum,
    output logic [COUNT_W-1:0]      o_sample_count
);

    localparam int CNT_W  = $clog2(WINDOW_MAX + 1);
    localparam int SLOT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_W  = VAL_W + CNT_W;
    localparam int DVD_W  = (SUM_W > RATE_W) ? SUM_W : RATE_W;
    localparam int DVS_W  = (CNT_W > MS_W) ? CNT_W : MS_W;
    localparam int IT_W   = $clog2(DVD_W + 1);

    localparam logic [DVD_W-1:0] POS_LIM = DVD_W'(32'h7FFF_FFFF);
    localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(32'h8000_0000);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state                  r_state, n_state;
    logic [CFG_DATA_W-1:0]   r_win_size;
    logic                    r_delta;
    logic signed [VAL_W-1:0] r_prev, n_prev;
    logic [SLOT_W-1:0]       r_slot, n_slot;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic signed [VAL_W-1:0] r_min, n_min;
    logic signed [VAL_W-1:0] r_max, n_max;
    logic                    r_out_vld, n_out_vld;

    logic [MS_W-1:0]         r_ms, n_ms;
    logic signed [VAL_W:0]   r_diff, n_diff;
    logic signed [VAL_W-1:0] r_val, n_val;
    logic signed [VAL_W-1:0] r_avg, n_avg;
    logic signed [VAL_W-1:0] r_o_last, n_o_last;
    logic signed [VAL_W-1:0] r_o_avg, n_o_avg;
    logic signed [VAL_W-1:0] r_o_min, n_o_min;
    logic signed [VAL_W-1:0] r_o_max, n_o_max;
    logic [COUNT_W-1:0]      r_o_cnt, n_o_cnt;

    // ------------------------------------------------------------------
    // Combinational helpers
    // ------------------------------------------------------------------
    logic                    acc;
    logic [CNT_W-1:0]        n_eff;
    logic [VAL_W-1:0]        diff_mag;
    logic [RATE_W-1:0]       prod;
    logic [SLOT_W:0]         slot_p1;
    logic [SUM_W-1:0]        sum_mag;
    logic                    seed;

    logic                    div_start;
    logic [DVD_W-1:0]        div_dvd;
    logic [DVS_W-1:0]        div_dvs;
    logic [IT_W-1:0]         div_iters;
    logic                    div_done;
    logic [DVD_W-1:0]        div_quo;
    logic [DVS_W-1:0]        div_rem;

    logic                    wr_en;
    logic [SLOT_W-1:0]       wr_slot;
    logic                    walk_go;

    t_walk                   link [WINDOW_MAX+1];
    logic signed [SUM_W-1:0] lsum [WINDOW_MAX+1];

    assign o_in_stall = (r_state != S_IDLE);
    assign acc        = i_in_valid && !o_in_stall;

    // Effective window: zero acts as one, oversize clamps to the depth
    always_comb begin
        if (r_win_size == '0) begin
            n_eff = CNT_W'(1);
        end else if (32'(r_win_size) > WINDOW_MAX) begin
            n_eff = CNT_W'(WINDOW_MAX);
        end else begin
            n_eff = CNT_W'(r_win_size);
        end
    end

    // Rate numerator magnitude, sum magnitude and next slot
    assign diff_mag = r_diff[VAL_W] ? VAL_W'(-r_diff) : VAL_W'(r_diff);
    assign prod     = RATE_W'(diff_mag) * RATE_W'(RATE_SCALE);
    assign sum_mag  = r_sum[SUM_W-1] ? (~$unsigned(r_sum) + 1'b1) : $unsigned(r_sum);
    assign slot_p1  = {1'b0, r_slot} + 1'b1;
    assign seed     = (r_fill == '0) || (r_delta && (r_fill == CNT_W'(1)));

    // ------------------------------------------------------------------
    // Next state and datapath control
    // ------------------------------------------------------------------
    always_comb begin
        n_state   = r_state;
        n_prev    = r_prev;
        n_slot    = r_slot;
        n_fill    = r_fill;
        n_sum     = r_sum;
        n_min     = r_min;
        n_max     = r_max;
        n_ms      = r_ms;
        n_diff    = r_diff;
        n_val     = r_val;
        n_avg     = r_avg;
        n_o_last  = r_o_last;
        n_o_avg   = r_o_avg;
        n_o_min   = r_o_min;
        n_o_max   = r_o_max;
        n_o_cnt   = r_o_cnt;
        n_out_vld = r_out_vld && i_out_stall;

        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = DVS_W'(1);
        div_iters = '0;
        wr_en     = 1'b0;
        wr_slot   = r_slot;
        walk_go   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                // Take a sample; zero milliseconds counts as one
                if (acc) begin
                    n_ms = (i_elapsed_ms == '0) ? MS_W'(1) : i_elapsed_ms;
                    if (r_delta) begin
                        n_diff  = (r_fill != '0)
                                ? ({i_sample_value[VAL_W-1], i_sample_value}
                                   - {r_prev[VAL_W-1], r_prev})
                                : '0;
                        n_prev  = i_sample_value;
                        n_state = S_RATE;
                    end else begin
                        n_val   = i_sample_value;
                        n_state = S_PLACE;
                    end
                end
            end

            S_RATE: begin
                // Divide |diff| * 1000 by the elapsed milliseconds
                div_start = 1'b1;
                div_dvd   = DVD_W'(prod) << (DVD_W - RATE_W);
                div_dvs   = DVS_W'(r_ms);
                div_iters = IT_W'(RATE_W);
                n_state   = S_RATE_WAIT;
            end

            S_RATE_WAIT: begin
                // Restore the sign and saturate to 32 bits
                if (div_done) begin
                    if (!r_diff[VAL_W]) begin
                        n_val = (div_quo > POS_LIM) ? VAL_MAX : div_quo[VAL_W-1:0];
                    end else begin
                        n_val = (div_quo > NEG_LIM) ? VAL_MIN
                              : (VAL_W'(0) - div_quo[VAL_W-1:0]);
                    end
                    n_state = S_PLACE;
                end
            end

            S_PLACE: begin
                if (r_fill < n_eff) begin
                    // Filling: store in the next slot and update incrementally
                    if (r_fill != '0) begin
                        wr_slot = (slot_p1 >= (SLOT_W + 1)'(WINDOW_MAX))
                                ? '0 : slot_p1[SLOT_W-1:0];
                    end
                    wr_en  = 1'b1;
                    n_slot = wr_slot;
                    if (seed) begin
                        n_min = r_val;
                        n_max = r_val;
                    end else begin
                        n_min = (r_val < r_min) ? r_val : r_min;
                        n_max = (r_val > r_max) ? r_val : r_max;
                    end
                    n_fill  = r_fill + 1'b1;
                    n_sum   = r_sum + SUM_W'(r_val);
                    n_state = S_AVG;
                end else begin
                    // Full: next slot is (slot + 1) mod window
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(slot_p1) << (DVD_W - SLOT_W - 1);
                    div_dvs   = DVS_W'(n_eff);
                    div_iters = IT_W'(SLOT_W + 1);
                    n_state   = S_MOD_WAIT;
                end
            end

            S_MOD_WAIT: begin
                // Overwrite the oldest value
                if (div_done) begin
                    wr_en   = 1'b1;
                    wr_slot = div_rem[SLOT_W-1:0];
                    n_slot  = wr_slot;
                    n_fill  = n_eff;
                    n_state = S_WALK_GO;
                end
            end

            S_WALK_GO: begin
                // Launch the totals token down the cell chain
                walk_go = 1'b1;
                n_state = S_WALK;
            end

            S_WALK: begin
                // Collect the recomputed totals at the end of the chain
                if (link[WINDOW_MAX].vld) begin
                    n_sum   = lsum[WINDOW_MAX];
                    n_min   = link[WINDOW_MAX].mn;
                    n_max   = link[WINDOW_MAX].mx;
                    n_state = S_AVG;
                end
            end

            S_AVG: begin
                // Average by division when more than one value is held
                if (r_fill > CNT_W'(1)) begin
                    div_start = 1'b1;
                    div_dvd   = DVD_W'(sum_mag) << (DVD_W - SUM_W);
                    div_dvs   = DVS_W'(r_fill);
                    div_iters = IT_W'(SUM_W);
                    n_state   = S_AVG_WAIT;
                end else begin
                    n_avg   = r_val;
                    n_state = S_OUT;
                end
            end

            S_AVG_WAIT: begin
                if (div_done) begin
                    n_avg   = r_sum[SUM_W-1] ? (VAL_W'(0) - div_quo[VAL_W-1:0])
                                             : div_quo[VAL_W-1:0];
                    n_state = S_OUT;
                end
            end

            S_OUT: begin
                // Load the output register once it is free
                if (!r_out_vld || !i_out_stall) begin
                    n_o_last  = r_val;
                    n_o_avg   = r_avg;
                    n_o_min   = r_min;
                    n_o_max   = r_max;
                    n_o_cnt   = COUNT_W'(r_fill);
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State register and control/statistics state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_prev    <= '0;
            r_slot    <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_min     <= '0;
            r_max     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_prev    <= n_prev;
            r_slot    <= n_slot;
            r_fill    <= n_fill;
            r_sum     <= n_sum;
            r_min     <= n_min;
            r_max     <= n_max;
            r_out_vld <= n_out_vld;
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_size <= WIN_SIZE_RST;
            r_delta    <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_WINDOW_SIZE: r_win_size <= i_cfg_data;
                CFG_DELTA_MODE:  r_delta    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_ms     <= n_ms;
        r_diff   <= n_diff;
        r_val    <= n_val;
        r_avg    <= n_avg;
        r_o_last <= n_o_last;
        r_o_avg  <= n_o_avg;
        r_o_min  <= n_o_min;
        r_o_max  <= n_o_max;
        r_o_cnt  <= n_o_cnt;
    end

    // ------------------------------------------------------------------
    // Shared divider
    // ------------------------------------------------------------------
    wss_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dvd   (div_dvd),
        .i_dvs   (div_dvs),
        .i_iters (div_iters),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    // ------------------------------------------------------------------
    // Chain of window cells
    // ------------------------------------------------------------------
    // Feed neutral totals into the chain; raise the token for one cycle
    assign link[0] = {walk_go, VAL_MAX, VAL_MIN};
    assign lsum[0] = '0;

    for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
        wss_cell #(
            .IDX    (g),
            .CNT_W  (CNT_W),
            .SLOT_W (SLOT_W),
            .SUM_W  (SUM_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_n       (n_eff),
            .i_wr_en   (wr_en),
            .i_wr_slot (wr_slot),
            .i_wr_data (r_val),
            .i_link    (link[g]),
            .i_sum     (lsum[g]),
            .o_link    (link[g+1]),
            .o_sum     (lsum[g+1])
        );
    end

    // Outputs
    assign o_out_valid      = r_out_vld;
    assign o_last_value     = r_o_last;
    assign o_window_average = r_o_avg;
    assign o_window_minimum = r_o_min;
    assign o_window_maximum = r_o_max;
    assign o_sample_count   = r_o_cnt;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fill) <= WINDOW_MAX))
        else $error("fill count beyond window depth");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_slot) < WINDOW_MAX))
        else $error("write slot beyond window depth");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_RATE_WAIT || r_state == S_MOD_WAIT
                      || r_state == S_AVG_WAIT))
        else $error("divider finished outside a wait state");

    a_walk_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        link[WINDOW_MAX].vld |-> (r_state == S_WALK))
        else $error("walk token arrived outside the walk state");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> o_in_stall)
        else $error("second transfer taken while a sample is in work");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !r_out_vld) |=> (r_out_vld && r_state == S_IDLE))
        else $error("result not loaded into a free output register");

endmodule

/* rtl/core/wss_cell.sv */
// ============================================================================
// wss_cell - one slot of the sliding window
// Stores one value and, inside the active window, folds it into the passing
// sum, minimum and maximum from the previous cell, handing them to the next.
// ============================================================================
module wss_cell
    import wss_pkg::*;
#(
    parameter int IDX    = 0,
    parameter int CNT_W  = 5,
    parameter int SLOT_W = 4,
    parameter int SUM_W  = 37
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [CNT_W-1:0]        i_n,
    input  logic                    i_wr_en,
    input  logic [SLOT_W-1:0]       i_wr_slot,
    input  logic signed [VAL_W-1:0] i_wr_data,
    input  t_walk                   i_link,
    input  logic signed [SUM_W-1:0] i_sum,
    output t_walk                   o_link,
    output logic signed [SUM_W-1:0] o_sum
);

    logic signed [VAL_W-1:0] r_val;
    logic                    r_vld;
    logic signed [VAL_W-1:0] r_mn;
    logic signed [VAL_W-1:0] r_mx;
    logic signed [SUM_W-1:0] r_sum;
    logic                    incl;

    // Slot takes part only while it lies inside the active window
    assign incl = (CNT_W'(IDX) < i_n);

    // Hold the stored value; reset clears the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= '0;
        end else if (i_wr_en && (i_wr_slot == SLOT_W'(IDX))) begin
            r_val <= i_wr_data;
        end
    end

    // Advance the token flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_link.vld;
        end
    end

    // Fold this slot into the passing totals
    always_ff @(posedge i_clk) begin
        if (incl) begin
            r_sum <= i_sum + SUM_W'(r_val);
            r_mn  <= (r_val < i_link.mn) ? r_val : i_link.mn;
            r_mx  <= (r_val > i_link.mx) ? r_val : i_link.mx;
        end else begin
            r_sum <= i_sum;
            r_mn  <= i_link.mn;
            r_mx  <= i_link.mx;
        end
    end

    assign o_link.vld = r_vld;
    assign o_link.mn  = r_mn;
    assign o_link.mx  = r_mx;
    assign o_sum      = r_sum;

endmodule

/* rtl/core/wss_div.sv */
// ============================================================================
// wss_div - shared unsigned restoring divider
// Produces one quotient bit per cycle. The dividend is left aligned by the
// caller so that only i_iters steps are needed for narrow operands.
// ============================================================================
module wss_div #(
    parameter  int DVD_W = 42,
    parameter  int DVS_W = 16,
    localparam int IT_W  = $clog2(DVD_W + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dvd,
    input  logic [DVS_W-1:0] i_dvs,
    input  logic [IT_W-1:0]  i_iters,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quo,
    output logic [DVS_W-1:0] o_rem
);

    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [IT_W-1:0]  r_cnt, n_cnt;
    logic             r_done, n_done;
    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   rem_sub;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        rem_sh  = {r_rem, r_quo[DVD_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
        if (i_start) begin
            n_quo = i_dvd;
            n_rem = '0;
            n_dvs = i_dvs;
            n_cnt = i_iters;
        end else if (r_cnt != '0) begin
            if (!rem_sub[DVS_W]) begin
                n_rem = rem_sub[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = rem_sh[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt  = r_cnt - 1'b1;
            n_done = (r_cnt == IT_W'(1));
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule
